[rtl/core/xlb_pkg.sv]
// xlb_pkg: shared opcodes and controller/datapath interface types
// for the xor linear basis unit; no dependencies
package xlb_pkg;

    localparam int OPCODE_W  = 3;
    localparam int OPERAND_W = 64;
    localparam int RESULT_W  = 64;

    localparam logic [OPCODE_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CONTAINS = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_MAX      = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_MIN      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_KTH      = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_RANK     = 3'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture a new item
        logic check;  // kth range check, walk setup
        logic rd;     // read the row at idx
        logic fix;    // this read belongs to the insert fix-up pass
        logic fin;    // commit state, load the result register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic x_zero;  // reduced word is zero
        logic h_top;   // leading bit of reduced word is the top row
    } sts_t;

endpackage

[rtl/core/xlb_ctrl.sv]
// xlb_ctrl: sequencer that walks the basis rows for each item
// depends on xlb_pkg
module xlb_ctrl #(
    parameter int WIDTH = 64,
    parameter int IW    = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [xlb_pkg::OPCODE_W-1:0]  opcode,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  xlb_pkg::sts_t                 sts,
    input  logic [IW-1:0]                 h,
    output xlb_pkg::cmd_t                 cmd,
    output logic [IW-1:0]                 idx
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_WALK, S_DRAIN, S_DECIDE, S_FIX, S_FDRAIN, S_FIN
    } state_t;

    localparam logic [IW-1:0] TOP_IDX = IW'(WIDTH - 1);

    state_t                         state_reg, state_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [xlb_pkg::OPCODE_W-1:0]   op_reg, op_next;
    logic                           full_reg, full_next;
    logic                           desc;

    assign desc = (op_reg == xlb_pkg::OP_INSERT) || (op_reg == xlb_pkg::OP_CONTAINS)
               || (op_reg == xlb_pkg::OP_RANK);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        full_next  = full_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = opcode;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                idx_next   = desc ? TOP_IDX : '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.rd = 1'b1;
                if (desc ? (idx_reg == '0) : (idx_reg == TOP_IDX))
                    state_next = S_DRAIN;
                else if (desc)
                    idx_next = idx_reg - IW'(1);
                else
                    idx_next = idx_reg + IW'(1);
            end
            S_DRAIN:
                state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (op_reg == xlb_pkg::OP_INSERT && !sts.x_zero && !sts.h_top)
                begin
                    idx_next   = h + IW'(1);
                    state_next = S_FIX;
                end
                else
                    state_next = S_FIN;
            end
            S_FIX:
            begin
                cmd.rd  = 1'b1;
                cmd.fix = 1'b1;
                if (idx_reg == TOP_IDX)
                    state_next = S_FDRAIN;
                else
                    idx_next = idx_reg + IW'(1);
            end
            S_FDRAIN:
                state_next = S_FIN;
            S_FIN:
            begin
                if (!full_reg || out_ready)
                begin
                    cmd.fin    = 1'b1;
                    full_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            op_reg    <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
            full_reg  <= full_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = full_reg;
    assign idx       = idx_reg;

endmodule

[rtl/core/xlb_datapath.sv]
// xlb_datapath: row memory, valid bits, per-row reduce/query step and result register
// depends on xlb_pkg
module xlb_datapath #(
    parameter int WIDTH = 64,
    parameter int IW    = 6,
    parameter int CW    = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  xlb_pkg::cmd_t                 cmd,
    input  logic [IW-1:0]                 idx,
    input  logic [xlb_pkg::OPCODE_W-1:0]  opcode,
    input  logic [xlb_pkg::OPERAND_W-1:0] operand,
    output xlb_pkg::sts_t                 sts,
    output logic [IW-1:0]                 h,
    output logic [xlb_pkg::RESULT_W-1:0]  result_value,
    output logic                          result_flag
);

    localparam logic [IW-1:0] TOP_IDX = IW'(WIDTH - 1);

    logic [WIDTH-1:0] mem [WIDTH];
    logic [WIDTH-1:0] rd_data_reg;

    // control state
    logic [WIDTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             dep_reg, dep_next;
    logic             p_en_reg, p_fix_reg;
    logic [IW-1:0]    p_idx_reg;

    // item payload
    logic [xlb_pkg::OPCODE_W-1:0]  op_reg, op_next;
    logic [WIDTH-1:0]              x_reg, x_next;
    logic [xlb_pkg::OPERAND_W-1:0] m_reg, m_next;
    logic [WIDTH-1:0]              acc_reg, acc_next;
    logic                          found_reg, found_next;
    logic [IW-1:0]                 h_reg, h_next;
    logic [IW-1:0]                 j_reg, j_next;
    logic                          kill_reg, kill_next;
    logic                          kflag_reg, kflag_next;
    logic [xlb_pkg::RESULT_W-1:0]  res_reg, res_next;
    logic                          rflag_reg, rflag_next;

    logic             we;
    logic [IW-1:0]    wa;
    logic [WIDTH-1:0] wd;
    logic             v;
    logic [WIDTH-1:0] row;
    logic [WIDTH-1:0] m_lo;
    logic [CW-1:0]    cm1;

    assign v    = valid_reg[p_idx_reg];
    assign row  = v ? rd_data_reg : '0;
    assign m_lo = m_reg[WIDTH-1:0];
    assign cm1  = count_reg - CW'(1);

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        dep_next   = dep_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        m_next     = m_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        h_next     = h_reg;
        j_next     = j_reg;
        kill_next  = kill_reg;
        kflag_next = kflag_reg;
        res_next   = res_reg;
        rflag_next = rflag_reg;
        we = 1'b0;
        wa = p_idx_reg;
        wd = rd_data_reg ^ x_reg;

        if (cmd.load)
        begin
            op_next    = opcode;
            x_next     = operand[WIDTH-1:0];
            m_next     = operand - xlb_pkg::OPERAND_W'(dep_reg);
            acc_next   = '0;
            found_next = 1'b0;
            h_next     = '0;
        end

        if (cmd.check)
        begin
            // m of zero yields zero; bits at or above the row count are out of range
            kill_next  = (m_reg == '0) || ((m_reg >> count_reg) != '0);
            kflag_next = (m_reg != '0) && ((m_reg >> count_reg) != '0);
            j_next     = (op_reg == xlb_pkg::OP_RANK) ? cm1[IW-1:0] : '0;
        end

        if (p_en_reg && p_fix_reg)
        begin
            // clear the new leading bit from higher rows
            we = v && rd_data_reg[h_reg];
        end
        else if (p_en_reg)
        begin
            case (op_reg)
                xlb_pkg::OP_INSERT, xlb_pkg::OP_CONTAINS:
                begin
                    if (x_reg[p_idx_reg] && v)
                        x_next = x_reg ^ row;
                    if (!found_reg && x_reg[p_idx_reg] && !v)
                    begin
                        found_next = 1'b1;
                        h_next     = p_idx_reg;
                    end
                end
                xlb_pkg::OP_MAX:
                    acc_next = acc_reg ^ row;
                xlb_pkg::OP_MIN:
                begin
                    if (!found_reg && v)
                    begin
                        acc_next   = row;
                        found_next = 1'b1;
                    end
                end
                xlb_pkg::OP_KTH:
                begin
                    if (v)
                    begin
                        if (m_lo[j_reg])
                            acc_next = acc_reg ^ row;
                        j_next = j_reg + IW'(1);
                    end
                end
                xlb_pkg::OP_RANK:
                begin
                    if (v)
                    begin
                        if (x_reg >= row)
                        begin
                            acc_next[j_reg] = 1'b1;
                            x_next          = x_reg ^ row;
                        end
                        j_next = j_reg - IW'(1);
                    end
                end
                default:
                    acc_next = acc_reg;
            endcase
        end

        if (cmd.fin)
        begin
            res_next   = '0;
            rflag_next = 1'b0;
            case (op_reg)
                xlb_pkg::OP_INSERT:
                begin
                    if (x_reg == '0)
                        dep_next = 1'b1;
                    else
                    begin
                        we                = 1'b1;
                        wa                = h_reg;
                        wd                = x_reg;
                        valid_next[h_reg] = 1'b1;
                        count_next        = count_reg + CW'(1);
                    end
                end
                xlb_pkg::OP_CONTAINS:
                    rflag_next = (x_reg == '0);
                xlb_pkg::OP_MAX:
                    res_next = xlb_pkg::RESULT_W'(acc_reg);
                xlb_pkg::OP_MIN:
                    res_next = dep_reg ? '0 : xlb_pkg::RESULT_W'(acc_reg);
                xlb_pkg::OP_KTH:
                begin
                    res_next   = kill_reg ? '0 : xlb_pkg::RESULT_W'(acc_reg);
                    rflag_next = kflag_reg;
                end
                xlb_pkg::OP_RANK:
                    res_next = xlb_pkg::RESULT_W'(acc_reg) + xlb_pkg::RESULT_W'(dep_reg);
                default:
                    res_next = '0;
            endcase
        end
    end

    // row store, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (cmd.rd)
            rd_data_reg <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            dep_reg   <= 1'b0;
            p_en_reg  <= 1'b0;
            p_fix_reg <= 1'b0;
            p_idx_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            dep_reg   <= dep_next;
            p_en_reg  <= cmd.rd;
            p_fix_reg <= cmd.fix;
            p_idx_reg <= idx;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        m_reg     <= m_next;
        acc_reg   <= acc_next;
        found_reg <= found_next;
        h_reg     <= h_next;
        j_reg     <= j_next;
        kill_reg  <= kill_next;
        kflag_reg <= kflag_next;
        res_reg   <= res_next;
        rflag_reg <= rflag_next;
    end

    assign sts.x_zero  = (x_reg == '0);
    assign sts.h_top   = (h_reg == TOP_IDX);
    assign h           = h_reg;
    assign result_value = res_reg;
    assign result_flag  = rflag_reg;

endmodule

[rtl/core/xor_linear_basis_unit.sv]
// xor_linear_basis_unit: per beat a range check, a walk over all rows, drain and decide;
// an insert with new leading bit h adds a fix-up walk over the rows above h, then commits
// throughput: one beat at a time, a new beat enters only once the last one is committed
// the result register lets the next beat enter while a result waits on the master side
// rst_n asynchronous active low: basis empty (valid bits cleared), no dependent seen
// depends on xlb_pkg, xlb_ctrl, xlb_datapath
module xor_linear_basis_unit #(
    parameter int WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // opcode [2:0], operand [66:3], zero pad [71:67]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // result_value [63:0], result_flag [64], zero pad [71:65]
);

    // row index and row count widths
    localparam int IW = (WIDTH > 2) ? $clog2(WIDTH) : 1;
    localparam int CW = $clog2(WIDTH + 1);

    xlb_pkg::cmd_t              cmd;
    xlb_pkg::sts_t              sts;
    logic [IW-1:0]              idx;
    logic [IW-1:0]              h;
    logic [xlb_pkg::RESULT_W-1:0] result_value;
    logic                       result_flag;

    // sequencer: walk order, fix-up pass, result handshake
    xlb_ctrl #(
        .WIDTH (WIDTH),
        .IW    (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tdata[2:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .h         (h),
        .cmd       (cmd),
        .idx       (idx)
    );

    // row store and per-row step
    xlb_datapath #(
        .WIDTH (WIDTH),
        .IW    (IW),
        .CW    (CW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .opcode       (s_tdata[2:0]),
        .operand      (s_tdata[66:3]),
        .sts          (sts),
        .h            (h),
        .result_value (result_value),
        .result_flag  (result_flag)
    );

    assign m_tdata = {7'd0, result_flag, result_value};

endmodule

[test/xor_linear_basis_unit_tb.sv]
// xor_linear_basis_unit_tb: self-checking bench for the xor linear basis unit
// holds its own gf(2) basis predictor, random stall/idle on both stream sides
// depends on xlb_pkg and xor_linear_basis_unit
`timescale 1ns / 100ps

module xor_linear_basis_unit_tb;

    localparam int CYCLE_LIMIT = 800000;
    localparam int DUE_DEPTH   = 64;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // opcode [2:0], operand [66:3], zero pad [71:67]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // result_value [63:0], result_flag [64], zero pad [71:65]

    typedef struct packed {
        logic [63:0] value;
        logic        flag;
    } answer_t;

    // predictor state: one row per leading bit, reduced echelon form
    logic [63:0] rows [64];
    logic        dep_seen;

    // expected answers in beat order
    answer_t answers_due [DUE_DEPTH];
    int      due_head;
    int      due_count;
    int      mismatches;
    int      cycles;
    bit      hold_off;

    xor_linear_basis_unit #(.WIDTH(64)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL xor_linear_basis_unit");
            $finish;
        end
    end

    function automatic logic [63:0] reduce_word(logic [63:0] x);
        for (int i = 63; i >= 0; i--)
            if (x[i] && rows[i] != 0)
                x ^= rows[i];
        return x;
    endfunction

    // updates predictor state and returns the answer the block should give
    function automatic answer_t basis_answer(logic [2:0] op, logic [63:0] x);
        answer_t a;
        logic [63:0] r, m;
        logic [63:0] list [64];
        int n, h;
        a = '0;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (rows[i] != 0)
            begin
                list[n] = rows[i];
                n++;
            end
        case (op)
            xlb_pkg::OP_INSERT:
            begin
                r = reduce_word(x);
                if (r == 0)
                    dep_seen = 1'b1;
                else
                begin
                    h = 63;
                    while (!r[h])
                        h--;
                    for (int i = h + 1; i < 64; i++)
                        if (rows[i][h])
                            rows[i] ^= r;
                    rows[h] = r;
                end
            end
            xlb_pkg::OP_CONTAINS: a.flag = (reduce_word(x) == 0);
            xlb_pkg::OP_MAX:
                for (int i = 0; i < 64; i++)
                    a.value ^= rows[i];
            xlb_pkg::OP_MIN:
                if (!dep_seen && n > 0)
                    a.value = list[0];
            xlb_pkg::OP_KTH:
            begin
                m = x - 64'(dep_seen);
                if (m != 0)
                begin
                    if (n < 64 && (m >> n) != 0)
                        a.flag = 1'b1;
                    else
                        for (int i = 0; i < n; i++)
                            if (m[i])
                                a.value ^= list[i];
                end
            end
            xlb_pkg::OP_RANK:
            begin
                for (int i = n - 1; i >= 0; i--)
                    if (x >= list[i])
                    begin
                        a.value += 64'd1 << i;
                        x ^= list[i];
                    end
                a.value += 64'(dep_seen);
            end
            default: ;
        endcase
        return a;
    endfunction

    // one beat on the slave side, with a random gap before it
    // tvalid stays high into the next beat when that gap is zero
    task automatic send_beat(logic [2:0] op, logic [63:0] x);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, x, op};
        answers_due[(due_head + due_count) % DUE_DEPTH] = basis_answer(op, x);
        due_count++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // drop tvalid after the last beat of a burst
    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // master side: per-beat random wait, plus a long hold-off on request
    initial
    begin
        int wait_left;
        m_tready  = 1'b0;
        wait_left = $urandom_range(0, 11);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                wait_left = $urandom_range(0, 11);
                if ($urandom_range(0, 3) == 0)
                    wait_left = 0;
            end
            else if (wait_left > 0)
                wait_left--;
            m_tready <= !hold_off && (wait_left == 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_count == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end
            else
            begin
                want      = answers_due[due_head];
                due_head  = (due_head + 1) % DUE_DEPTH;
                due_count--;
                if (m_tdata[63:0] !== want.value || m_tdata[64] !== want.flag
                    || m_tdata[71:65] !== 7'b0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %h flag %b, got value %h flag %b",
                                 want.value, want.flag, m_tdata[63:0], m_tdata[64]);
                end
            end
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // sparse words so low ranks stay reachable
    function automatic logic [63:0] rand_sparse();
        logic [63:0] w;
        w = 64'd1 << $urandom_range(0, 63);
        if ($urandom_range(0, 1))
            w ^= 64'd1 << $urandom_range(0, 63);
        return w;
    endfunction

    task automatic test_empty_basis();
        send_beat(xlb_pkg::OP_MAX, 64'd0);
        send_beat(xlb_pkg::OP_MIN, 64'd0);
        send_beat(xlb_pkg::OP_KTH, 64'd0);
        send_beat(xlb_pkg::OP_KTH, 64'd1);
        send_beat(xlb_pkg::OP_RANK, '1);
        send_beat(xlb_pkg::OP_CONTAINS, 64'd0);
        send_beat(xlb_pkg::OP_CONTAINS, 64'd1);
        send_beat(3'd6, '1);
        send_beat(3'd7, 64'd5);
    endtask

    task automatic test_directed_ops();
        send_beat(xlb_pkg::OP_INSERT, '1);
        send_beat(xlb_pkg::OP_INSERT, 64'd1);
        send_beat(xlb_pkg::OP_INSERT, 64'h8000_0000_0000_0000);
        send_beat(xlb_pkg::OP_MAX, 64'd0);
        send_beat(xlb_pkg::OP_MIN, 64'd0);
        send_beat(xlb_pkg::OP_KTH, 64'd3);
        send_beat(xlb_pkg::OP_KTH, 64'd8);
        send_beat(xlb_pkg::OP_RANK, 64'h7fff_ffff_ffff_ffff);
        send_beat(xlb_pkg::OP_CONTAINS, 64'h7fff_ffff_ffff_fffe);
        // dependent insert: min drops to zero, kth counts from one
        send_beat(xlb_pkg::OP_INSERT, 64'd0);
        send_beat(xlb_pkg::OP_MIN, 64'd0);
        send_beat(xlb_pkg::OP_KTH, 64'd0);
        send_beat(xlb_pkg::OP_KTH, 64'd1);
        send_beat(xlb_pkg::OP_RANK, '1);
    endtask

    // fill all 64 rows so the full-rank kth path and wraps are hit
    task automatic test_full_rank();
        for (int i = 0; i < 64; i++)
            send_beat(xlb_pkg::OP_INSERT, (64'd1 << i) | rand_word() & ((64'd1 << i) - 1));
        send_beat(xlb_pkg::OP_KTH, '1);
        send_beat(xlb_pkg::OP_KTH, 64'd0);
        send_beat(xlb_pkg::OP_RANK, '1);
        send_beat(xlb_pkg::OP_MAX, 64'd0);
        send_beat(xlb_pkg::OP_CONTAINS, rand_word());
    endtask

    // receiver stalls long while the sender keeps offering beats
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_beat(3'($urandom_range(1, 5)), rand_word());
                stop_sending();
            end
        join
    endtask

    task automatic test_random(int count);
        logic [2:0]  op;
        logic [63:0] x;
        for (int i = 0; i < count; i++)
        begin
            op = 3'($urandom_range(0, 7));
            if (op > 5 && $urandom_range(0, 3) != 0)
                op = xlb_pkg::OP_INSERT;
            case ($urandom_range(0, 3))
                0: x = rand_sparse();
                1: x = rand_word();
                2: x = 64'($urandom_range(0, 300));
                default: x = rows[$urandom_range(0, 63)] ^ rand_sparse();
            endcase
            send_beat(op, x);
        end
    endtask

    task automatic wait_drain();
        stop_sending();
        while (due_count != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 64; i++)
            rows[i] = '0;
        dep_seen   = 1'b0;
        due_head   = 0;
        due_count  = 0;
        mismatches = 0;
        cycles     = 0;
        hold_off   = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_basis();
        test_directed_ops();
        test_backpressure();
        test_random(450);
        test_full_rank();
        test_random(450);
        wait_drain();

        if (mismatches == 0)
            $display("PASS xor_linear_basis_unit");
        else
            $display("FAIL xor_linear_basis_unit");
        $finish;
    end

endmodule
